/* src/assert_macros.svh */
// Assertion macros shared by the RTL in this folder.
// Needs a clock and an active-high synchronous reset in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/ipv4hc_pkg.sv */
// Types and constants for the IPv4 receive header check.
// No dependencies.
`default_nettype none

package ipv4hc_pkg;

   localparam int unsigned HEADER_WORDS = 10;
   localparam int unsigned WORD_WIDTH   = 16;
   localparam int unsigned ADDR_WIDTH   = 32;
   localparam int unsigned PROTO_WIDTH  = 8;
   localparam int unsigned CSR_INDEX_WIDTH = 1;

   typedef logic [3:0] word_index_type;

   localparam word_index_type WORD_COUNT_IDLE = word_index_type'(HEADER_WORDS);
   localparam word_index_type WORD_VER_IHL    = 4'd0;
   localparam word_index_type WORD_FRAGMENT   = 4'd3;
   localparam word_index_type WORD_PROTOCOL   = 4'd4;
   localparam word_index_type WORD_SRC_HIGH   = 4'd6;
   localparam word_index_type WORD_SRC_LOW    = 4'd7;
   localparam word_index_type WORD_DST_HIGH   = 4'd8;
   localparam word_index_type WORD_DST_LOW    = 4'd9;

   localparam logic [3:0]  IHL_NO_OPTIONS  = 4'd5;
   localparam logic [15:0] CHECKSUM_GOOD   = 16'hFFFF;

   localparam logic [PROTO_WIDTH-1:0] PROTO_ICMP = 8'd1;
   localparam logic [PROTO_WIDTH-1:0] PROTO_TCP  = 8'd6;
   localparam logic [PROTO_WIDTH-1:0] PROTO_UDP  = 8'd17;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_LOCAL_ADDRESS     = 1'd0,
      CSR_BROADCAST_ADDRESS = 1'd1
   } csr_index_type;

   typedef enum logic [2:0] {
      VERDICT_UDP          = 3'd0,
      VERDICT_TCP          = 3'd1,
      VERDICT_ICMP         = 3'd2,
      VERDICT_PROTO_UNREACH = 3'd3,
      VERDICT_NOT_US       = 3'd4,
      VERDICT_BAD_CHECKSUM = 3'd5,
      VERDICT_OPTIONS      = 3'd6,
      VERDICT_FRAGMENT     = 3'd7
   } verdict_type;

endpackage

`default_nettype wire

/* src/ipv4_rx_header_check_unit.sv */
// IPv4 receive header check: folds ten header words into one verdict.
// Depends on ipv4hc_pkg and assert_macros.svh.
//
//   channel | direction | handshake        | payload
//   req     | in        | valid / ready    | header_word, first_word
//   rsp     | out       | valid / ready    | verdict, source_address, protocol
//   csr     | in        | write enable     | index, write_data
//
// One word per cycle unless stalled; verdict in the cycle after word ten.
// The result register sits between the word accumulator and the rsp side:
// a request is taken while the result register is empty or being taken.
// Reset (synchronous) closes any open header and clears both addresses.
`default_nettype none
`include "assert_macros.svh"

module ipv4_rx_header_check_unit (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      req_valid,
   output logic                                           req_ready,
   input  wire logic [ipv4hc_pkg::WORD_WIDTH-1:0]         req_header_word,
   input  wire logic                                      req_first_word,
   output logic                                           rsp_valid,
   input  wire logic                                      rsp_ready,
   output logic [2:0]                                     rsp_verdict,
   output logic [ipv4hc_pkg::ADDR_WIDTH-1:0]              rsp_source_address,
   output logic [ipv4hc_pkg::PROTO_WIDTH-1:0]             rsp_protocol,
   input  wire logic                                      csr_write_enable,
   input  wire logic [ipv4hc_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  wire logic [ipv4hc_pkg::ADDR_WIDTH-1:0]         csr_write_data
);
   import ipv4hc_pkg::*;

   logic [ADDR_WIDTH-1:0]  local_address_ff, local_address_in;
   logic [ADDR_WIDTH-1:0]  broadcast_address_ff, broadcast_address_in;

   word_index_type         word_count_ff, word_count_in;
   logic [WORD_WIDTH-1:0]  checksum_sum_ff, checksum_sum_in;
   logic [ADDR_WIDTH-1:0]  source_capture_ff, source_capture_in;
   logic [WORD_WIDTH-1:0]  dest_upper_half_ff, dest_upper_half_in;
   logic                   length_ok_ff, length_ok_in;
   logic                   fragment_seen_ff, fragment_seen_in;
   logic [PROTO_WIDTH-1:0] protocol_capture_ff, protocol_capture_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   verdict_type            rsp_verdict_ff, rsp_verdict_in;
   logic [ADDR_WIDTH-1:0]  rsp_source_address_ff, rsp_source_address_in;
   logic [PROTO_WIDTH-1:0] rsp_protocol_ff, rsp_protocol_in;

   logic                   req_accept;
   logic                   header_open;
   logic                   word_active;
   logic                   result_fire;
   word_index_type         word_index;
   logic [WORD_WIDTH-1:0]  sum_base;
   logic [WORD_WIDTH:0]    sum_wide;
   logic [WORD_WIDTH:0]    sum_fold;
   logic [ADDR_WIDTH-1:0]  dest_address;
   verdict_type            verdict;

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   assign header_open = (word_count_ff < WORD_COUNT_IDLE);
   assign word_active = req_accept && (req_first_word || header_open);
   assign word_index  = req_first_word ? WORD_VER_IHL : word_count_ff;
   assign result_fire = word_active && (word_index == WORD_DST_LOW);

   // ones-complement add with end-around carry
   assign sum_base = req_first_word ? '0 : checksum_sum_ff;
   assign sum_wide = {1'b0, sum_base} + {1'b0, req_header_word};
   assign sum_fold = {1'b0, sum_wide[WORD_WIDTH-1:0]}
                   + {{WORD_WIDTH{1'b0}}, sum_wide[WORD_WIDTH]};

   assign dest_address = {dest_upper_half_ff, req_header_word};

   always_comb begin
      if (dest_address != local_address_ff && dest_address != broadcast_address_ff) begin
         verdict = VERDICT_NOT_US;
      end else if (sum_fold[WORD_WIDTH-1:0] != CHECKSUM_GOOD) begin
         verdict = VERDICT_BAD_CHECKSUM;
      end else if (!length_ok_ff) begin
         verdict = VERDICT_OPTIONS;
      end else if (fragment_seen_ff) begin
         verdict = VERDICT_FRAGMENT;
      end else if (protocol_capture_ff == PROTO_UDP) begin
         verdict = VERDICT_UDP;
      end else if (protocol_capture_ff == PROTO_TCP) begin
         verdict = VERDICT_TCP;
      end else if (protocol_capture_ff == PROTO_ICMP) begin
         verdict = VERDICT_ICMP;
      end else begin
         verdict = VERDICT_PROTO_UNREACH;
      end
   end

   always_comb begin
      local_address_in     = local_address_ff;
      broadcast_address_in = broadcast_address_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_LOCAL_ADDRESS:     local_address_in = csr_write_data;
            CSR_BROADCAST_ADDRESS: broadcast_address_in = csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      word_count_in       = word_count_ff;
      checksum_sum_in     = checksum_sum_ff;
      source_capture_in   = source_capture_ff;
      dest_upper_half_in  = dest_upper_half_ff;
      length_ok_in        = length_ok_ff;
      fragment_seen_in    = fragment_seen_ff;
      protocol_capture_in = protocol_capture_ff;
      if (word_active) begin
         word_count_in   = word_index + 4'd1;
         checksum_sum_in = sum_fold[WORD_WIDTH-1:0];
         case (word_index)
            WORD_VER_IHL:  length_ok_in = (req_header_word[11:8] == IHL_NO_OPTIONS);
            WORD_FRAGMENT: fragment_seen_in = (req_header_word[12:0] != 13'd0);
            WORD_PROTOCOL: protocol_capture_in = req_header_word[PROTO_WIDTH-1:0];
            WORD_SRC_HIGH: source_capture_in[ADDR_WIDTH-1:WORD_WIDTH] = req_header_word;
            WORD_SRC_LOW:  source_capture_in[WORD_WIDTH-1:0] = req_header_word;
            WORD_DST_HIGH: dest_upper_half_in = req_header_word;
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in          = rsp_valid_ff && !rsp_ready;
      rsp_verdict_in        = rsp_verdict_ff;
      rsp_source_address_in = rsp_source_address_ff;
      rsp_protocol_in       = rsp_protocol_ff;
      if (result_fire) begin
         rsp_valid_in          = 1'b1;
         rsp_verdict_in        = verdict;
         rsp_source_address_in = source_capture_ff;
         rsp_protocol_in       = protocol_capture_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         local_address_ff     <= '0;
         broadcast_address_ff <= '0;
         word_count_ff        <= WORD_COUNT_IDLE;
         checksum_sum_ff      <= '0;
         source_capture_ff    <= '0;
         dest_upper_half_ff   <= '0;
         length_ok_ff         <= 1'b0;
         fragment_seen_ff     <= 1'b0;
         protocol_capture_ff  <= '0;
         rsp_valid_ff         <= 1'b0;
      end else begin
         local_address_ff     <= local_address_in;
         broadcast_address_ff <= broadcast_address_in;
         word_count_ff        <= word_count_in;
         checksum_sum_ff      <= checksum_sum_in;
         source_capture_ff    <= source_capture_in;
         dest_upper_half_ff   <= dest_upper_half_in;
         length_ok_ff         <= length_ok_in;
         fragment_seen_ff     <= fragment_seen_in;
         protocol_capture_ff  <= protocol_capture_in;
         rsp_valid_ff         <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_verdict_ff        <= rsp_verdict_in;
      rsp_source_address_ff <= rsp_source_address_in;
      rsp_protocol_ff       <= rsp_protocol_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_verdict        = rsp_verdict_ff;
   assign rsp_source_address = rsp_source_address_ff;
   assign rsp_protocol       = rsp_protocol_ff;

   `ASSERT_CLK(a_count_range, clock, reset, word_count_ff <= WORD_COUNT_IDLE, "word count out of range")
   `ASSERT_NEXT(a_stray_word_silent, clock, reset, req_accept && !req_first_word && !header_open, !rsp_valid_ff, "word outside a header produced a result")
   `ASSERT_CLK(a_new_result_closes, clock, reset, !$rose(rsp_valid_ff) || word_count_ff == WORD_COUNT_IDLE, "result issued with header still open")
   `ASSERT_CLK(a_udp_protocol, clock, reset, !(rsp_valid_ff && rsp_verdict_ff == VERDICT_UDP) || rsp_protocol_ff == PROTO_UDP, "udp verdict with other protocol")

endmodule

`default_nettype wire

/* bench/testbench.sv */
// Testbench for ipv4_rx_header_check_unit: streams IPv4 header words and checks each verdict
// against an in-bench prediction, under several address settings and flow-control mixes.
// Depends on ipv4hc_pkg and the unit from src/.
module testbench;
   import ipv4hc_pkg::*;

   typedef logic [HEADER_WORDS-1:0][WORD_WIDTH-1:0] header_image_type;

   typedef struct packed {
      verdict_type            verdict;
      logic [ADDR_WIDTH-1:0]  source_address;
      logic [PROTO_WIDTH-1:0] protocol;
   } verdict_record_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [WORD_WIDTH-1:0]      req_header_word = '0;
   logic                       req_first_word = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [2:0]                 rsp_verdict;
   logic [ADDR_WIDTH-1:0]      rsp_source_address;
   logic [PROTO_WIDTH-1:0]     rsp_protocol;
   logic                       csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [ADDR_WIDTH-1:0]      csr_write_data = '0;

   ipv4_rx_header_check_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_header_word    (req_header_word),
      .req_first_word     (req_first_word),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_verdict        (rsp_verdict),
      .rsp_source_address (rsp_source_address),
      .rsp_protocol       (rsp_protocol),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   // predicted unit state
   logic [ADDR_WIDTH-1:0]  local_addr_cfg = '0;
   logic [ADDR_WIDTH-1:0]  bcast_addr_cfg = '0;
   word_index_type         header_word_count = WORD_COUNT_IDLE;
   logic [WORD_WIDTH-1:0]  running_sum = '0;
   logic [ADDR_WIDTH-1:0]  captured_source = '0;
   logic [WORD_WIDTH-1:0]  captured_dest_high = '0;
   logic                   ihl_ok = 1'b0;
   logic                   offset_nonzero = 1'b0;
   logic [PROTO_WIDTH-1:0] captured_protocol = '0;

   verdict_record_type pending_verdicts[$];

   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int hold_off_cycles = 0;
   int error_count = 0;
   int words_accepted = 0;
   int verdicts_checked = 0;
   int settings_applied = 0;
   int verdict_tally[8] = '{default: 0};

   initial forever #10 clock = ~clock;

   initial begin
      #4000000;
      $display("Simulation FAILED");
      $finish;
   end

   function automatic logic [WORD_WIDTH-1:0] ones_complement_add(logic [WORD_WIDTH-1:0] a,
                                                               logic [WORD_WIDTH-1:0] b);
      logic [WORD_WIDTH:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[WORD_WIDTH-1:0] + WORD_WIDTH'(s[WORD_WIDTH]);
   endfunction

   task automatic fold_header_word(input logic [WORD_WIDTH-1:0] w, input logic f);
      word_index_type        slot;
      logic [ADDR_WIDTH-1:0] dest;
      verdict_record_type    rec;
      if (f) begin
         slot = WORD_VER_IHL;
         running_sum = '0;
      end else if (header_word_count >= WORD_COUNT_IDLE) begin
         return;
      end else begin
         slot = header_word_count;
      end
      running_sum = ones_complement_add(running_sum, w);
      case (slot)
         WORD_VER_IHL:  ihl_ok = (w[11:8] == IHL_NO_OPTIONS);
         WORD_FRAGMENT: offset_nonzero = (w[12:0] != '0);
         WORD_PROTOCOL: captured_protocol = w[7:0];
         WORD_SRC_HIGH: captured_source[31:16] = w;
         WORD_SRC_LOW:  captured_source[15:0] = w;
         WORD_DST_HIGH: captured_dest_high = w;
         default: ;
      endcase
      header_word_count = slot + 4'd1;
      if (slot != WORD_DST_LOW) return;
      dest = {captured_dest_high, w};
      if (dest != local_addr_cfg && dest != bcast_addr_cfg) rec.verdict = VERDICT_NOT_US;
      else if (running_sum != CHECKSUM_GOOD) rec.verdict = VERDICT_BAD_CHECKSUM;
      else if (!ihl_ok) rec.verdict = VERDICT_OPTIONS;
      else if (offset_nonzero) rec.verdict = VERDICT_FRAGMENT;
      else if (captured_protocol == PROTO_UDP) rec.verdict = VERDICT_UDP;
      else if (captured_protocol == PROTO_TCP) rec.verdict = VERDICT_TCP;
      else if (captured_protocol == PROTO_ICMP) rec.verdict = VERDICT_ICMP;
      else rec.verdict = VERDICT_PROTO_UNREACH;
      rec.source_address = captured_source;
      rec.protocol = captured_protocol;
      pending_verdicts.push_back(rec);
   endtask

   always @(posedge clock) begin
      verdict_record_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_verdicts.size() == 0) begin
            $error("unexpected verdict %0d from source %08h", rsp_verdict, rsp_source_address);
            error_count++;
         end else begin
            want = pending_verdicts.pop_front();
            verdicts_checked++;
            verdict_tally[want.verdict]++;
            if (rsp_verdict !== want.verdict) begin
               $error("verdict: expected %0d (%s), got %0d", want.verdict, want.verdict.name(),
                      rsp_verdict);
               error_count++;
            end
            if (rsp_source_address !== want.source_address) begin
               $error("source_address: expected %08h, got %08h", want.source_address,
                      rsp_source_address);
               error_count++;
            end
            if (rsp_protocol !== want.protocol) begin
               $error("protocol: expected %02h, got %02h", want.protocol, rsp_protocol);
               error_count++;
            end
         end
      end
   end

   // receiver: long hold-off when requested, otherwise random stalls
   always @(negedge clock) begin
      if (hold_off_cycles > 0) begin
         rsp_ready <= 1'b0;
         hold_off_cycles = hold_off_cycles - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   task automatic send_request(input logic [WORD_WIDTH-1:0] w, input logic f);
      while ($urandom_range(99) < sender_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_header_word <= w;
      req_first_word <= f;
      do @(posedge clock); while (!req_ready);
      fold_header_word(w, f);
      words_accepted++;
   endtask

   task automatic send_header(input header_image_type h);
      for (int i = 0; i < HEADER_WORDS; i++) send_request(h[i], i == 0);
   endtask

   task automatic write_address_register(input csr_index_type idx,
                                         input logic [ADDR_WIDTH-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_LOCAL_ADDRESS) local_addr_cfg = value;
      else bcast_addr_cfg = value;
   endtask

   task automatic apply_addresses(input logic [ADDR_WIDTH-1:0] local_value,
                                  input logic [ADDR_WIDTH-1:0] bcast_value);
      write_address_register(CSR_LOCAL_ADDRESS, local_value);
      write_address_register(CSR_BROADCAST_ADDRESS, bcast_value);
      settings_applied++;
   endtask

   // finish any open header, drain verdicts, leave the unit quiet
   task automatic settle_block();
      int waited;
      while (header_word_count < WORD_COUNT_IDLE) send_request(16'($urandom), 1'b0);
      @(negedge clock);
      req_valid <= 1'b0;
      waited = 0;
      while (pending_verdicts.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      if (pending_verdicts.size() != 0) begin
         $error("%0d verdicts never arrived", pending_verdicts.size());
         error_count++;
         pending_verdicts.delete();
      end
      repeat (4) @(posedge clock);
   endtask

   function automatic header_image_type build_header(input logic [ADDR_WIDTH-1:0] dest,
                                                     input logic [ADDR_WIDTH-1:0] src,
                                                     input logic [PROTO_WIDTH-1:0] proto,
                                                     input logic [3:0] ihl,
                                                     input logic [WORD_WIDTH-1:0] flags_offset,
                                                     input bit good_sum);
      header_image_type      h;
      logic [WORD_WIDTH-1:0] sum;
      h[0] = {4'($urandom), ihl, 8'($urandom)};
      h[1] = 16'($urandom_range(1500, 20));
      h[2] = 16'($urandom);
      h[3] = flags_offset;
      h[4] = {8'($urandom), proto};
      h[5] = '0;
      h[6] = src[31:16];
      h[7] = src[15:0];
      h[8] = dest[31:16];
      h[9] = dest[15:0];
      sum = '0;
      for (int i = 0; i < HEADER_WORDS; i++) sum = ones_complement_add(sum, h[i]);
      h[5] = good_sum ? ~sum : ~sum ^ 16'($urandom_range(65535, 1));
      return h;
   endfunction

   function automatic header_image_type random_header();
      logic [ADDR_WIDTH-1:0]  dest;
      logic [PROTO_WIDTH-1:0] proto;
      logic [3:0]             ihl;
      logic [12:0]            offset;
      int                     pick;
      pick = $urandom_range(99);
      dest = (pick < 40) ? local_addr_cfg : (pick < 65) ? bcast_addr_cfg : 32'($urandom);
      case ($urandom_range(3))
         0: proto = PROTO_UDP;
         1: proto = PROTO_TCP;
         2: proto = PROTO_ICMP;
         default: proto = 8'($urandom);
      endcase
      ihl = ($urandom_range(99) < 85) ? IHL_NO_OPTIONS : 4'($urandom);
      offset = ($urandom_range(99) < 80) ? 13'd0 : 13'($urandom);
      return build_header(dest, 32'($urandom), proto, ihl, {3'($urandom), offset},
                          $urandom_range(99) < 85);
   endfunction

   task automatic test_dispatch_and_drop_codes();
      logic [ADDR_WIDTH-1:0] me;
      logic [ADDR_WIDTH-1:0] peer;
      me = 32'hC0A8_0001;
      peer = 32'h0A00_0002;
      apply_addresses(me, 32'hFFFF_FFFF);
      send_header(build_header(me, peer, PROTO_UDP, IHL_NO_OPTIONS, 16'h0000, 1'b1));
      send_header(build_header(32'hFFFF_FFFF, peer, PROTO_TCP, IHL_NO_OPTIONS, 16'h0000, 1'b1));
      send_header(build_header(me, peer, PROTO_ICMP, IHL_NO_OPTIONS, 16'h0000, 1'b1));
      send_header(build_header(me, peer, 8'h00, IHL_NO_OPTIONS, 16'h0000, 1'b1));
      send_header(build_header(me, peer, 8'hFF, IHL_NO_OPTIONS, 16'h0000, 1'b1));
      send_header(build_header(me + 32'd1, peer, PROTO_UDP, IHL_NO_OPTIONS, 16'h0000, 1'b1));
      send_header(build_header(me, peer, PROTO_UDP, IHL_NO_OPTIONS, 16'h0000, 1'b0));
      send_header(build_header(me, peer, PROTO_UDP, 4'd6, 16'h0000, 1'b1));
      send_header(build_header(me, peer, PROTO_UDP, 4'd15, 16'h0000, 1'b1));
      send_header(build_header(me, peer, PROTO_UDP, 4'd0, 16'h0000, 1'b1));
      send_header(build_header(me, peer, PROTO_TCP, IHL_NO_OPTIONS, 16'h0001, 1'b1));
      send_header(build_header(me, peer, PROTO_TCP, IHL_NO_OPTIONS, 16'hFFFF, 1'b1));
      // flag bits with a zero offset are not a fragment
      send_header(build_header(me, peer, PROTO_UDP, IHL_NO_OPTIONS, 16'h2000, 1'b1));
      send_header(build_header(me, peer, PROTO_UDP, IHL_NO_OPTIONS, 16'hE000, 1'b1));
      // check precedence
      send_header(build_header(me - 32'd1, peer, PROTO_UDP, 4'd7, 16'h0100, 1'b0));
      send_header(build_header(me, peer, PROTO_UDP, 4'd7, 16'h0100, 1'b0));
      send_header(build_header(me, peer, PROTO_UDP, 4'd7, 16'h0100, 1'b1));
      settle_block();
   endtask

   task automatic test_framing_special_cases();
      header_image_type h;
      send_request(16'h1234, 1'b0);
      send_request(16'hFFFF, 1'b0);
      h = random_header();
      for (int i = 0; i < 4; i++) send_request(h[i], i == 0);
      send_header(random_header());
      for (int i = 0; i < 9; i++) send_request(h[i], i == 0);
      send_header(random_header());
      send_header(random_header());
      send_request(16'hA5A5, 1'b0);
      send_request(16'h0000, 1'b0);
      // every word all ones: broadcast, good sum, bad IHL
      send_header('1);
      settle_block();
      apply_addresses(32'h0000_0000, 32'hFFFF_FFFF);
      send_header('0);
      settle_block();
   endtask

   task automatic test_address_extremes();
      logic [ADDR_WIDTH-1:0] settings[4][2];
      settings = '{'{32'h0, 32'h0}, '{32'hFFFF_FFFF, 32'hFFFF_FFFF},
                   '{32'h0, 32'hFFFF_FFFF}, '{32'hFFFF_FFFF, 32'h0}};
      for (int s = 0; s < 4; s++) begin
         apply_addresses(settings[s][0], settings[s][1]);
         send_header(build_header(32'h0, 32'hFFFF_FFFF, PROTO_UDP, IHL_NO_OPTIONS,
                                  16'h0000, 1'b1));
         send_header(build_header(32'hFFFF_FFFF, 32'h0, PROTO_TCP, IHL_NO_OPTIONS,
                                  16'h0000, 1'b1));
         send_header(build_header(32'h8000_0001, 32'($urandom), PROTO_ICMP, IHL_NO_OPTIONS,
                                  16'h0000, 1'b1));
         settle_block();
      end
   endtask

   task automatic run_traffic_phase(input int n_words, input int idle_pct, input int stall_pct);
      header_image_type h;
      int               start;
      int               pick;
      int               cut;
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      start = words_accepted;
      while (words_accepted - start < n_words) begin
         pick = $urandom_range(99);
         h = random_header();
         if (pick < 80) begin
            send_header(h);
         end else if (pick < 88) begin
            cut = $urandom_range(9, 1);
            for (int i = 0; i < cut; i++) send_request(h[i], i == 0);
         end else if (pick < 94) begin
            send_request(16'($urandom), 1'($urandom));
         end else begin
            for (int i = 0; i < HEADER_WORDS; i++)
               send_request(16'($urandom), i == 0 || $urandom_range(19) == 0);
         end
      end
      settle_block();
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
   endtask

   task automatic test_random_traffic();
      apply_addresses(32'($urandom), 32'hFFFF_FFFF);
      run_traffic_phase(200, 0, 0);
      apply_addresses(32'($urandom), 32'($urandom));
      run_traffic_phase(200, 74, 0);
      apply_addresses(32'($urandom), 32'h0000_0000);
      run_traffic_phase(200, 0, 74);
      apply_addresses(32'hFFFF_FFFF, 32'($urandom));
      run_traffic_phase(200, 33, 33);
   endtask

   task automatic test_input_backpressure();
      apply_addresses(32'hC0A8_0A0A, 32'hC0A8_0AFF);
      hold_off_cycles = 400;
      for (int n = 0; n < 8; n++) send_header(random_header());
      settle_block();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_dispatch_and_drop_codes();
      test_framing_special_cases();
      test_address_extremes();
      test_random_traffic();
      test_input_backpressure();
      $display("Checked %0d verdicts from %0d header words over %0d address settings",
               verdicts_checked, words_accepted, settings_applied);
      $display("udp %0d tcp %0d icmp %0d unreach %0d not-us %0d csum %0d opts %0d frag %0d",
               verdict_tally[0], verdict_tally[1], verdict_tally[2], verdict_tally[3],
               verdict_tally[4], verdict_tally[5], verdict_tally[6], verdict_tally[7]);
      if (error_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end
endmodule
